// ----- rtl/wsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared constants and types for the windowed deviation touch detector.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned SumW   = 24;
  localparam int unsigned SqW    = 36;
  localparam int unsigned CntW   = 13;
  localparam int unsigned BaseW  = 15;
  localparam int unsigned MeanW  = 16;
  localparam int unsigned FracW  = 16;
  localparam int unsigned UpdW   = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegWindowLen = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAlphaInit = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAlphaSlow = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInitUpd   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd4;

  // Request from the accumulator to the serial math unit.
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [SqW-1:0]  sq;
    logic [CntW-1:0] n;
  } wsd_win_t;

endpackage
`default_nettype wire

// ----- rtl/windowed_stdev_touch_detector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_stdev_touch_detector_unit
// Windowed mean and deviation of ADC samples with an adaptive touch baseline.
// ----------------------------------------------------------------------------
// Each sample is squared bit-serially and accumulated, and the next sample
// can be taken once the squaring of the previous one is done. The closing
// sample of a window starts a shift-add, square-root and restoring-divide
// sequence, which is shorter when the window is a touch or the baseline is
// still zero; the result transaction is then offered and is held until it
// is handed over. Samples keep
// being taken while a result waits; only the sample that closes the next
// window stalls at the end of its squaring until the waiting result is gone.
module windowed_stdev_touch_detector_unit #(
  parameter int unsigned MaxWindow  = 4096,
  parameter int unsigned SampleBits = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [11:0] sample_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [14:0]      std_dev_o,
  output logic [15:0]      mean_level_o,
  output logic [14:0]      baseline_level_o,
  output logic             touched_o,
  output logic             touch_changed_o
);

  localparam logic [12:0] MaxN = 13'(MaxWindow > 4096 ? 4096 : MaxWindow);

  logic [12:0] wlen_q;
  logic [15:0] ainit_q, aslow_q, thr_q;
  logic [7:0]  iupd_q;
  logic [23:0] sum_q;
  logic [35:0] sq_q;
  logic [12:0] cnt_q;
  logic        busy_q, sqr_q, close_q, ov_q;
  logic [4:0]  bit_q;
  logic [23:0] prod_q, mc_q;
  logic [11:0] mp_q, x;
  logic [12:0] n;
  wsd_pkg::wsd_win_t win_q;
  logic        done;
  logic        hold, sq_last;
  logic [14:0] sd, bl;
  logic [15:0] mn;
  logic        tc, tg;

  assign x = sample_i & 12'((32'd1 << SampleBits) - 32'd1);
  assign n = (wlen_q == 13'd0) ? 13'd1 : ((wlen_q > MaxN) ? MaxN : wlen_q);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o = !busy_q;
  assign hold = sqr_q && (bit_q == 5'd11) && (cnt_q >= n) && ov_q && !out_ready_i;
  assign sq_last = sqr_q && !hold && (bit_q == 5'd11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= 13'd4096; ainit_q <= 16'd13107; aslow_q <= 16'd6554;
      iupd_q <= 8'd50; thr_q <= 16'd3277;
      sum_q <= '0; sq_q <= '0; cnt_q <= '0;
      busy_q <= 1'b0; sqr_q <= 1'b0; close_q <= 1'b0; ov_q <= 1'b0;
      bit_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          wsd_pkg::RegWindowLen: wlen_q <= cfg_data_i[12:0];
          wsd_pkg::RegAlphaInit: ainit_q <= cfg_data_i;
          wsd_pkg::RegAlphaSlow: aslow_q <= cfg_data_i;
          wsd_pkg::RegInitUpd:   iupd_q <= cfg_data_i[7:0];
          wsd_pkg::RegThreshold: thr_q <= cfg_data_i;
          default: ;
        endcase
      end
      close_q <= sq_last && (cnt_q >= n);
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1; sqr_q <= 1'b1; bit_q <= '0;
        sum_q <= sum_q + {12'd0, x};
        cnt_q <= cnt_q + 13'd1;
      end else if (sqr_q && !hold) begin
        bit_q <= bit_q + 5'd1;
        if (bit_q == 5'd11) begin
          sqr_q <= 1'b0;
          if (cnt_q >= n) begin
            sum_q <= '0; cnt_q <= '0; sq_q <= '0;
          end else begin
            busy_q <= 1'b0;
            sq_q <= sq_q + {12'd0, (mp_q[0] ? prod_q + mc_q : prod_q)};
          end
        end
      end
      if (done) begin
        busy_q <= 1'b0; ov_q <= 1'b1;
      end else if (ov_q && out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      prod_q <= '0; mc_q <= {12'd0, x}; mp_q <= x;
    end else if (sqr_q && !hold) begin
      if (mp_q[0]) prod_q <= prod_q + mc_q;
      mc_q <= {mc_q[22:0], 1'b0};
      mp_q <= {1'b0, mp_q[11:1]};
      if (bit_q == 5'd11) begin
        win_q.sum <= sum_q;
        win_q.sq <= sq_q + {12'd0, (mp_q[0] ? prod_q + mc_q : prod_q)};
        win_q.n <= n;
      end
    end
  end

  wsd_math u_math (
    .clk_i, .rst_ni,
    .start_i(close_q),
    .win_i(win_q),
    .fast_wt_i(ainit_q), .slow_wt_i(aslow_q),
    .init_updates_i(iupd_q), .threshold_frac_i(thr_q),
    .done_o(done),
    .std_dev_o(sd), .mean_level_o(mn), .baseline_level_o(bl),
    .touched_o(tg), .touch_changed_o(tc)
  );

  assign out_valid_o = ov_q;
  assign std_dev_o = sd;
  assign mean_level_o = mn;
  assign baseline_level_o = bl;
  assign touched_o = tg;
  assign touch_changed_o = tc;

endmodule
`default_nettype wire

// ----- rtl/wsd_math.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsd_math
// Bit-serial evaluation of deviation, mean and baseline for a closed window.
// ----------------------------------------------------------------------------
module wsd_math (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire wsd_pkg::wsd_win_t win_i,
  input  wire logic [15:0]       fast_wt_i,
  input  wire logic [15:0]       slow_wt_i,
  input  wire logic [7:0]        init_updates_i,
  input  wire logic [15:0]       threshold_frac_i,
  output logic                   done_o,
  output logic [14:0]            std_dev_o,
  output logic [15:0]            mean_level_o,
  output logic [14:0]            baseline_level_o,
  output logic                   touched_o,
  output logic                   touch_changed_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMulA = 4'd1;
  localparam logic [3:0] StMulB = 4'd2;
  localparam logic [3:0] StSqrt = 4'd3;
  localparam logic [3:0] StDivS = 4'd4;
  localparam logic [3:0] StDivM = 4'd5;
  localparam logic [3:0] StMarg = 4'd6;
  localparam logic [3:0] StDec  = 4'd7;
  localparam logic [3:0] StStep = 4'd8;
  localparam logic [3:0] StUpd  = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  // Shared shift-add accumulator and operand registers.
  logic [57:0] acc_q, acc_d;
  logic [57:0] mcand_q, mcand_d;
  logic [48:0] mplier_q, mplier_d;
  logic [57:0] a_q, a_d;
  logic [57:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [14:0] sd_q, sd_d;
  logic [15:0] mean_q, mean_d;
  logic [14:0] base_q, base_d;
  logic [7:0]  upd_q, upd_d;
  logic        flag_q, flag_d;
  logic        now_q, now_d;
  logic        chg_q, chg_d;
  logic        done_q, done_d;
  logic        neg_q, neg_d;

  logic [59:0] rtrial;
  logic [15:0] alpha;
  logic [16:0] sdiff;
  logic [15:0] stepv;
  logic [16:0] thr;

  assign alpha = (upd_q < init_updates_i) ? fast_wt_i : slow_wt_i;
  assign sdiff = {2'b0, sd_q} - {2'b0, base_q};
  assign thr   = {2'b0, base_q} + {2'b0, acc_q[30:16]};
  assign stepv = acc_q[31:16] + {15'd0, neg_q && (acc_q[15:0] != 16'd0)};

  always_comb begin
    rtrial = {rem_q, 2'b00} | {58'd0, a_q[57:56]};
    state_d = state_q; cnt_d = cnt_q; acc_d = acc_q; mcand_d = mcand_q;
    mplier_d = mplier_q; a_d = a_q; rem_d = rem_q; root_d = root_q;
    sd_d = sd_q; mean_d = mean_q; base_d = base_q; upd_d = upd_q;
    flag_d = flag_q; now_d = now_q; chg_d = chg_q; done_d = 1'b0; neg_d = neg_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          acc_d = '0;
          mcand_d = {22'd0, win_i.sq};
          mplier_d = {36'd0, win_i.n};
          cnt_d = 7'd0;
          state_d = StMulA;
        end
      end
      StMulA: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d = {mcand_q[56:0], 1'b0};
        mplier_d = {1'b0, mplier_q[48:1]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd12) begin
          a_d = (mplier_q[0] ? acc_q + mcand_q : acc_q);
          acc_d = '0;
          mcand_d = {34'd0, win_i.sum};
          mplier_d = {25'd0, win_i.sum};
          cnt_d = 7'd0;
          state_d = StMulB;
        end
      end
      StMulB: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d = {mcand_q[56:0], 1'b0};
        mplier_d = {1'b0, mplier_q[48:1]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd23) begin
          acc_d = mplier_q[0] ? acc_q + mcand_q : acc_q;
          if (a_q > acc_d) a_d = (a_q - acc_d) << 8;
          else a_d = '0;
          rem_d = '0; root_d = '0; cnt_d = 7'd0;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        a_d = {a_q[55:0], 2'b00};
        if (rtrial >= {26'd0, root_q, 2'b01}) begin
          rem_d = 58'(rtrial - {26'd0, root_q, 2'b01});
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d = rtrial[57:0];
          root_d = {root_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd28) begin
          rem_d = '0; a_d = {26'd0, root_d}; acc_d = '0; cnt_d = 7'd0;
          state_d = StDivS;
        end
      end
      StDivS: begin
        // Restoring divide by n, one quotient bit per cycle.
        rem_d = {rem_q[56:0], a_q[31]};
        a_d = {a_q[56:0], 1'b0};
        if ({rem_q[56:0], a_q[31]} >= {45'd0, win_i.n}) begin
          rem_d = {rem_q[56:0], a_q[31]} - {45'd0, win_i.n};
          acc_d = {acc_q[56:0], 1'b1};
        end else acc_d = {acc_q[56:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd31) begin
          sd_d = acc_d[14:0];
          rem_d = '0; a_d = {30'd0, win_i.sum, 4'd0}; acc_d = '0; cnt_d = 7'd0;
          state_d = StDivM;
        end
      end
      StDivM: begin
        rem_d = {rem_q[56:0], a_q[27]};
        a_d = {a_q[56:0], 1'b0};
        if ({rem_q[56:0], a_q[27]} >= {45'd0, win_i.n}) begin
          rem_d = {rem_q[56:0], a_q[27]} - {45'd0, win_i.n};
          acc_d = {acc_q[56:0], 1'b1};
        end else acc_d = {acc_q[56:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd27) begin
          mean_d = acc_d[15:0];
          acc_d = '0; mcand_d = {43'd0, base_q};
          mplier_d = {33'd0, threshold_frac_i}; cnt_d = 7'd0;
          state_d = StMarg;
        end
      end
      StMarg: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d = {mcand_q[56:0], 1'b0};
        mplier_d = {1'b0, mplier_q[48:1]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd15) state_d = StDec;
      end
      StDec: begin
        now_d = (base_q != 15'd0) && ({2'b0, sd_q} > thr);
        chg_d = now_d != flag_q;
        flag_d = now_d;
        neg_d = sdiff[16];
        acc_d = '0;
        mcand_d = {42'd0, (sdiff[16] ? 16'(-sdiff) : sdiff[15:0])};
        mplier_d = {33'd0, alpha};
        cnt_d = 7'd0;
        if (now_d) begin
          done_d = 1'b1; state_d = StIdle;
        end else if (base_q == 15'd0) begin
          base_d = sd_q; state_d = StUpd;
        end else state_d = StStep;
      end
      StStep: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d = {mcand_q[56:0], 1'b0};
        mplier_d = {1'b0, mplier_q[48:1]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd15) state_d = StUpd;
      end
      StUpd: begin
        if (base_q != 15'd0 && state_q == StUpd && cnt_q == 7'd16) begin
          base_d = neg_q ? base_q - stepv[14:0] : base_q + stepv[14:0];
        end
        if (upd_q != 8'hFF) upd_d = upd_q + 8'd1;
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; base_q <= '0; upd_q <= '0;
      flag_q <= 1'b0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; base_q <= base_d; upd_q <= upd_d;
      flag_q <= flag_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mcand_q <= mcand_d; mplier_q <= mplier_d; a_q <= a_d;
    rem_q <= rem_d; root_q <= root_d; sd_q <= sd_d; mean_q <= mean_d;
    now_q <= now_d; chg_q <= chg_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign std_dev_o = sd_q;
  assign mean_level_o = mean_q;
  assign baseline_level_o = base_q;
  assign touched_o = now_q;
  assign touch_changed_o = chg_q;

endmodule
`default_nettype wire
